// ===== hw/rtl/pngu_pkg.sv =====
`default_nettype none

package pngu_pkg;

    // widest line store index carried through the pixel queue
    localparam int COL_IDX_W = 13;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    localparam logic [10:0] SCREEN_NARROW = 11'd512;
    localparam logic [10:0] SCREEN_WIDE   = 11'd1024;

    localparam logic [11:0] IMG_WIDTH_RST = 12'd512;
    localparam logic [6:0]  BRIGHT_FULL   = 7'd100;

    // c = (v * 32 * br / 100) >> 8 = floor(v * br / 800) = (v * br * 5243) >> 22
    localparam logic [12:0] SCALE_RECIP = 13'd5243;
    localparam int          SCALE_SHIFT = 22;
    localparam logic [4:0]  CHAN_MAX    = 5'd31;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH = 3'd0,
        REG_HAS_ALPHA   = 3'd1,
        REG_WIDE_SCREEN = 3'd2,
        REG_ORIGIN_X    = 3'd3,
        REG_ORIGIN_Y    = 3'd4,
        REG_BRIGHTNESS  = 3'd5
    } reg_sel_t;

    // encodings match the filter byte of the stream
    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filt_t;

    typedef enum logic [2:0] {
        ST_FILTER,
        ST_RED,
        ST_GREEN,
        ST_BLUE,
        ST_ALPHA
    } front_state_t;

    // [2] red, [1] green, [0] blue
    typedef logic [2:0][7:0] rgb_t;

    typedef struct packed {
        logic [11:0] image_width;
        logic        has_alpha;
        logic        wide_screen;
        logic [9:0]  origin_x;
        logic [9:0]  origin_y;
        logic [6:0]  brightness;
    } cfg_t;

    typedef struct packed {
        rgb_t                 pix;
        filt_t                filt;
        logic [COL_IDX_W-1:0] col_idx;
        logic                 first_col;
        logic                 first_row;
        logic                 visible;
        logic [9:0]           screen_x;
        logic [9:0]           screen_y;
    } pix_rec_t;

endpackage

`default_nettype wire

// ===== hw/rtl/png_rgb_unfilter_to_rgb555.sv =====
// Path: a result passes the pixel queue, the read stage, the scale stage and the
// output register to m_*. Input: one byte beat per cycle while the queue is not
// full; a pixel spans 3 (RGB) or 4 (RGBA) beats, plus one filter beat per line.
// The back end pops a pixel only after the last one's line store write-back.
// Reset: aresetn (synchronous, active low) restores the registers and clears the
// decode state, queue and pipeline; the line store is not cleared.
`default_nettype none

module png_rgb_unfilter_to_rgb555 import pngu_pkg::*; #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_pixel_word,
    output logic [9:0]       m_screen_x,
    output logic [9:0]       m_screen_y
);

    cfg_t       cfg_reg;
    logic       wr_en;
    reg_sel_t   sel;
    logic       push;
    pix_rec_t   push_rec;
    logic       q_full;
    logic       q_empty;
    logic       pop;
    pix_rec_t   q_head;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign sel    = reg_sel_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width <= IMG_WIDTH_RST;
            cfg_reg.has_alpha   <= 1'b0;
            cfg_reg.wide_screen <= 1'b0;
            cfg_reg.origin_x    <= '0;
            cfg_reg.origin_y    <= '0;
            cfg_reg.brightness  <= BRIGHT_FULL;
        end else if (wr_en) begin
            unique case (sel)
                REG_IMAGE_WIDTH: cfg_reg.image_width <= pwdata[11:0];
                REG_HAS_ALPHA:   cfg_reg.has_alpha   <= pwdata[0];
                REG_WIDE_SCREEN: cfg_reg.wide_screen <= pwdata[0];
                REG_ORIGIN_X:    cfg_reg.origin_x    <= pwdata[9:0];
                REG_ORIGIN_Y:    cfg_reg.origin_y    <= pwdata[9:0];
                REG_BRIGHTNESS:  cfg_reg.brightness  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (sel)
            REG_IMAGE_WIDTH: prdata = 32'(cfg_reg.image_width);
            REG_HAS_ALPHA:   prdata = 32'(cfg_reg.has_alpha);
            REG_WIDE_SCREEN: prdata = 32'(cfg_reg.wide_screen);
            REG_ORIGIN_X:    prdata = 32'(cfg_reg.origin_x);
            REG_ORIGIN_Y:    prdata = 32'(cfg_reg.origin_y);
            REG_BRIGHTNESS:  prdata = 32'(cfg_reg.brightness);
            default:         prdata = '0;
        endcase
    end

    pngu_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .q_full      (q_full),
        .push        (push),
        .push_rec    (push_rec)
    );

    pngu_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    pngu_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .brightness   (cfg_reg.brightness),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_word (m_pixel_word),
        .m_screen_x   (m_screen_x),
        .m_screen_y   (m_screen_y)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/pngu_front.sv =====
`default_nettype none

module pngu_front import pngu_pkg::*; #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire cfg_t     cfg,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic     q_full,
    output logic          push,
    output pix_rec_t      push_rec
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (CW > 12) ? CW : 12;
    localparam int XW = ((CW > 10) ? CW : 10) + 1;

    front_state_t   state_reg, state_next;
    logic [CW-1:0]  column_reg, column_next;
    logic [10:0]    row_reg, row_next;
    filt_t          filt_reg, filt_next;
    logic [7:0]     red_reg, red_next;
    logic [7:0]     green_reg, green_next;

    logic           take;
    logic           drop;
    logic [10:0]    screen_size;
    logic [10:0]    row_y;
    logic [XW-1:0]  col_x;
    logic [EW-1:0]  img_w;
    logic [EW-1:0]  eff_width;
    logic [CW-1:0]  col_inc;
    logic [CW-1:0]  col_idx;
    filt_t          filt_dec;

    assign s_ready = !q_full;
    assign take    = s_valid && s_ready;

    assign screen_size = cfg.wide_screen ? SCREEN_WIDE : SCREEN_NARROW;
    assign row_y       = 11'(cfg.origin_y) + row_reg;
    assign drop        = row_y >= screen_size;   // row saturates once off screen
    assign col_x       = XW'(cfg.origin_x) + XW'(column_reg);

    assign img_w     = EW'(cfg.image_width);
    assign eff_width = (img_w == '0) ? EW'(1) :
                       (img_w > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : img_w;

    assign col_inc  = column_reg + CW'(1);
    assign col_idx  = (column_reg < CW'(MAX_WIDTH)) ? column_reg : CW'(MAX_WIDTH - 1);
    assign filt_dec = (s_data_byte <= {5'd0, FILT_PAETH}) ? filt_t'(s_data_byte[2:0])
                                                          : FILT_NONE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_FILTER;
            column_reg <= '0;
            row_reg    <= '0;
            filt_reg   <= FILT_NONE;
            red_reg    <= '0;
            green_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            column_reg <= column_next;
            row_reg    <= row_next;
            filt_reg   <= filt_next;
            red_reg    <= red_next;
            green_reg  <= green_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        column_next = column_reg;
        row_next    = row_reg;
        filt_next   = filt_reg;
        red_next    = red_reg;
        green_next  = green_reg;
        push        = 1'b0;
        if (take && !drop) begin
            unique case (state_reg)
                ST_FILTER: begin
                    filt_next   = filt_dec;
                    column_next = '0;
                    state_next  = ST_RED;
                end
                ST_RED: begin
                    red_next   = s_data_byte;
                    state_next = ST_GREEN;
                end
                ST_GREEN: begin
                    green_next = s_data_byte;
                    state_next = ST_BLUE;
                end
                ST_BLUE: begin
                    push        = 1'b1;
                    column_next = col_inc;
                    if (cfg.has_alpha) begin
                        state_next = ST_ALPHA;
                    end else if (EW'(col_inc) >= eff_width) begin
                        column_next = '0;
                        row_next    = row_reg + 11'd1;
                        state_next  = ST_FILTER;
                    end else begin
                        state_next = ST_RED;
                    end
                end
                ST_ALPHA: begin
                    if (EW'(column_reg) >= eff_width) begin
                        column_next = '0;
                        row_next    = row_reg + 11'd1;
                        state_next  = ST_FILTER;
                    end else begin
                        state_next = ST_RED;
                    end
                end
                default: state_next = ST_FILTER;
            endcase
        end
    end

    always_comb begin
        push_rec.pix       = {red_reg, green_reg, s_data_byte};
        push_rec.filt      = filt_reg;
        push_rec.col_idx   = COL_IDX_W'(col_idx);
        push_rec.first_col = (column_reg == '0);
        push_rec.first_row = (row_reg == '0);
        push_rec.visible   = col_x < XW'(screen_size);
        push_rec.screen_x  = col_x[9:0];
        push_rec.screen_y  = row_y[9:0];
    end

    a_blue_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BLUE) |-> (column_reg < CW'(MAX_WIDTH)))
        else $error("column past line store at blue beat");

endmodule

`default_nettype wire

// ===== hw/rtl/pngu_queue.sv =====
`default_nettype none

module pngu_queue import pngu_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire pix_rec_t push_rec,
    output logic          full,
    input  wire logic     pop,
    output logic          empty,
    output pix_rec_t      head
);

    pix_rec_t            slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    assign full  = (count_reg == (QPTR_W + 1)'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (QPTR_W + 1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (QPTR_W + 1)'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("pixel queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("pixel queue underflow");

endmodule

`default_nettype wire

// ===== hw/rtl/pngu_back.sv =====
`default_nettype none

module pngu_back import pngu_pkg::*; #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [6:0] brightness,
    input  wire logic       q_empty,
    input  wire pix_rec_t   q_head,
    output logic            pop,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [15:0]     m_pixel_word,
    output logic [9:0]      m_screen_x,
    output logic [9:0]      m_screen_y
);

    localparam int AW = $clog2(MAX_WIDTH);

    rgb_t           line_mem [MAX_WIDTH];
    rgb_t           line_q_reg;
    pix_rec_t       s1_rec_reg;
    logic           s1_valid_reg;
    rgb_t           left_reg;
    rgb_t           ul_reg;

    logic           s2_valid_reg;
    rgb_t           s2_pix_reg;
    logic [9:0]     s2_x_reg;
    logic [9:0]     s2_y_reg;

    logic [19:0]    gain_reg;
    logic           m_valid_reg;
    logic [15:0]    word_reg;
    logic [9:0]     x_reg;
    logic [9:0]     y_reg;

    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    logic           out_ready;
    logic           s2_ready;
    logic           s1_fire;
    rgb_t           cur;
    rgb_t           res;
    logic [6:0]     br_eff;
    logic [2:0][4:0] chan;
    logic [15:0]    word_next;

    function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        logic signed [9:0]  ta;
        logic signed [9:0]  tb;
        logic signed [10:0] tc;
        logic [10:0]        pa;
        logic [10:0]        pb;
        logic [10:0]        pc;
        begin
            // p - a = b - c, p - b = a - c, p - c = (b - c) + (a - c)
            ta = $signed({2'b00, b}) - $signed({2'b00, c});
            tb = $signed({2'b00, a}) - $signed({2'b00, c});
            tc = 11'(ta) + 11'(tb);
            pa = (ta < 0) ? -11'(ta) : 11'(ta);
            pb = (tb < 0) ? -11'(tb) : 11'(tb);
            pc = (tc < 0) ? -tc : tc;
            if (pa <= pb && pa <= pc) begin
                paeth_pred = a;
            end else if (pb <= pc) begin
                paeth_pred = b;
            end else begin
                paeth_pred = c;
            end
        end
    endfunction

    assign out_ready = !m_valid_reg || m_ready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_fire   = s1_valid_reg && s2_ready;
    // one pixel in the read stage at a time: the write of a pixel lands before
    // the next read, so a one-pixel-wide image needs no bypass
    assign pop       = !q_empty && !s1_valid_reg;
    assign rd_addr   = q_head.col_idx[AW-1:0];
    assign wr_addr   = s1_rec_reg.col_idx[AW-1:0];

    always_ff @(posedge aclk) begin
        if (pop) begin
            line_q_reg <= line_mem[rd_addr];
            s1_rec_reg <= q_head;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            line_mem[wr_addr] <= res;
        end
    end

    assign cur = s1_rec_reg.first_row ? '0 : line_q_reg;

    always_comb begin
        logic [7:0] lf;
        logic [7:0] up;
        logic [7:0] ul;
        logic [8:0] avg_sum;
        res = '0;
        for (int i = 0; i < 3; i++) begin
            lf      = s1_rec_reg.first_col ? 8'd0 : left_reg[i];
            up      = cur[i];
            ul      = (s1_rec_reg.first_col || s1_rec_reg.first_row) ? 8'd0 : ul_reg[i];
            avg_sum = 9'(lf) + 9'(up);
            case (s1_rec_reg.filt)
                FILT_SUB:   res[i] = s1_rec_reg.pix[i] + lf;
                FILT_UP:    res[i] = s1_rec_reg.pix[i] + up;
                FILT_AVG:   res[i] = s1_rec_reg.pix[i] + avg_sum[8:1];
                FILT_PAETH: res[i] = s1_rec_reg.pix[i] + paeth_pred(lf, up, ul);
                default:    res[i] = s1_rec_reg.pix[i];
            endcase
        end
    end

    assign br_eff = (brightness == '0) ? BRIGHT_FULL : brightness;

    always_comb begin
        logic [27:0] prod;
        chan = '0;
        for (int i = 0; i < 3; i++) begin
            prod    = 28'(s2_pix_reg[i]) * 28'(gain_reg);
            chan[i] = (prod[SCALE_SHIFT +: 6] > 6'(CHAN_MAX)) ? CHAN_MAX
                                                             : prod[SCALE_SHIFT +: 5];
        end
        word_next = {chan[1], chan[2], chan[0], 1'b1};
    end

    always_ff @(posedge aclk) begin
        gain_reg <= 20'(br_eff) * 20'(SCALE_RECIP);
        if (s1_fire) begin
            s2_pix_reg <= res;
            s2_x_reg   <= s1_rec_reg.screen_x;
            s2_y_reg   <= s1_rec_reg.screen_y;
        end
        if (s2_valid_reg && out_ready) begin
            word_reg <= word_next;
            x_reg    <= s2_x_reg;
            y_reg    <= s2_y_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            left_reg     <= '0;
            ul_reg       <= '0;
        end else begin
            if (pop) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire) begin
                s2_valid_reg <= s1_rec_reg.visible;
                left_reg     <= res;
                ul_reg       <= cur;
            end else if (out_ready) begin
                s2_valid_reg <= 1'b0;
            end
            if (out_ready) begin
                m_valid_reg <= s2_valid_reg;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_word = word_reg;
    assign m_screen_x   = x_reg;
    assign m_screen_y   = y_reg;

    a_visible_reaches_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && s1_rec_reg.visible) |=> s2_valid_reg)
        else $error("visible pixel lost after unfilter");

    a_scale_held_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && !out_ready) |=> s2_valid_reg)
        else $error("scale stage dropped a pixel while stalled");

endmodule

`default_nettype wire

// ===== bench/tb_png_rgb_unfilter_to_rgb555.sv =====
`default_nettype none

module tb_png_rgb_unfilter_to_rgb555;
    import pngu_pkg::*;

    localparam int LINE_MAX     = 2048;
    localparam int COVERED_COLS = 65;   // columns of the line store filled by the first row
    localparam int DRAIN_CYCLES = 24;
    localparam int REPORT_LIMIT = 10;
    localparam int MODE_BYTES   = 200;

    typedef struct packed {
        logic [15:0] word;
        logic [9:0]  sx;
        logic [9:0]  sy;
    } rgb555_beat_t;

    class rgb555_scoreboard;
        logic [11:0] width_r;
        logic        alpha_r;
        logic        wide_r;
        logic [9:0]  offx_r;
        logic [9:0]  offy_r;
        logic [6:0]  bright_r;

        bit          await_filter;
        int unsigned column;
        int unsigned row;
        int unsigned phase;
        logic [7:0]  red_b;
        logic [7:0]  green_b;
        filt_t       kind;
        rgb_t        left_px;
        rgb_t        upleft_px;
        rgb_t        line_mem [LINE_MAX];

        rgb555_beat_t pending [$];
        int unsigned decoded;
        int unsigned checked;
        int unsigned errors;

        function new();
            width_r      = IMG_WIDTH_RST;
            alpha_r      = 1'b0;
            wide_r       = 1'b0;
            offx_r       = '0;
            offy_r       = '0;
            bright_r     = BRIGHT_FULL;
            await_filter = 1'b1;
            column       = 0;
            row          = 0;
            phase        = 0;
            red_b        = '0;
            green_b      = '0;
            kind         = FILT_NONE;
            left_px      = '0;
            upleft_px    = '0;
            decoded      = 0;
            checked      = 0;
            errors       = 0;
        endfunction

        function void set_reg(reg_sel_t r, logic [31:0] v);
            case (r)
                REG_IMAGE_WIDTH: width_r  = v[11:0];
                REG_HAS_ALPHA:   alpha_r  = v[0];
                REG_WIDE_SCREEN: wide_r   = v[0];
                REG_ORIGIN_X:    offx_r   = v[9:0];
                REG_ORIGIN_Y:    offy_r   = v[9:0];
                REG_BRIGHTNESS:  bright_r = v[6:0];
                default: ;
            endcase
        endfunction

        function int unsigned screen();
            return wide_r ? SCREEN_WIDE : SCREEN_NARROW;
        endfunction

        // false while the current row sits below the screen
        function bit live();
            return (offy_r + row) < screen();
        endfunction

        function int unsigned eff_width();
            if (width_r == 0) return 1;
            if (width_r > LINE_MAX) return LINE_MAX;
            return width_r;
        endfunction

        function logic [4:0] scale5(logic [7:0] v);
            int unsigned br;
            int unsigned c;
            br = (bright_r == 0) ? BRIGHT_FULL : bright_r;
            c = ((v * 32 * br) / 100) >> 8;
            return (c > CHAN_MAX) ? CHAN_MAX : c[4:0];
        endfunction

        function logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
            int ia;
            int ib;
            int ic;
            int p;
            int pa;
            int pb;
            int pc;
            ia = a;
            ib = b;
            ic = c;
            p  = ia + ib - ic;
            pa = (p > ia) ? p - ia : ia - p;
            pb = (p > ib) ? p - ib : ib - p;
            pc = (p > ic) ? p - ic : ic - p;
            if (pa <= pb && pa <= pc) return a;
            if (pb <= pc) return b;
            return c;
        endfunction

        function void finish_pixel();
            phase = 0;
            if (column >= eff_width()) begin
                column       = 0;
                await_filter = 1'b1;
                row++;
            end
        endfunction

        function void note_input(logic [7:0] b);
            rgb_t         px;
            rgb_t         above;
            rgb_t         res;
            int           lf;
            int           up;
            int           ul;
            rgb555_beat_t beat;
            if (!live()) return;
            decoded++;
            if (await_filter) begin
                kind         = (b <= 4) ? filt_t'(b[2:0]) : FILT_NONE;
                await_filter = 1'b0;
                column       = 0;
                phase        = 0;
                return;
            end
            case (phase)
                0: begin
                    red_b = b;
                    phase = 1;
                end
                1: begin
                    green_b = b;
                    phase   = 2;
                end
                3: finish_pixel();
                default: begin
                    above = (row > 0) ? line_mem[column] : '0;
                    px    = {red_b, green_b, b};
                    for (int i = 0; i < 3; i++) begin
                        lf = (column > 0) ? left_px[i] : 0;
                        up = above[i];
                        ul = (column > 0 && row > 0) ? upleft_px[i] : 0;
                        case (kind)
                            FILT_SUB:   res[i] = 8'(px[i] + lf);
                            FILT_UP:    res[i] = 8'(px[i] + up);
                            FILT_AVG:   res[i] = 8'(px[i] + ((lf + up) >> 1));
                            FILT_PAETH: res[i] = px[i] + paeth_pick(8'(lf), 8'(up), 8'(ul));
                            default:    res[i] = px[i];
                        endcase
                    end
                    upleft_px        = above;
                    left_px          = res;
                    line_mem[column] = res;
                    if (offx_r + column < screen()) begin
                        beat.word = {scale5(res[1]), scale5(res[2]), scale5(res[0]), 1'b1};
                        beat.sx   = 10'(offx_r + column);
                        beat.sy   = 10'(offy_r + row);
                        pending.push_back(beat);
                    end
                    column++;
                    if (alpha_r) phase = 3;
                    else finish_pixel();
                end
            endcase
        endfunction

        function void check_result(logic [15:0] word, logic [9:0] sx, logic [9:0] sy);
            rgb555_beat_t want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected pixel beat: word %h x %0d y %0d", word, sx, sy);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (word !== want.word || sx !== want.sx || sy !== want.sy) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display({"pixel beat %0d mismatch: expected word %h x %0d y %0d, ",
                              "got word %h x %0d y %0d"},
                             checked, want.word, want.sx, want.sy, word, sx, sy);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_pixel_word;
    logic [9:0]  m_screen_x;
    logic [9:0]  m_screen_y;

    rgb555_scoreboard sb;
    int unsigned      send_idle;
    int unsigned      recv_idle;
    int unsigned      bytes_sent;
    int unsigned      settings;

    png_rgb_unfilter_to_rgb555 u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_word (m_pixel_word),
        .m_screen_x   (m_screen_x),
        .m_screen_y   (m_screen_y)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("timed out waiting for pixel beats");
        $display("tb_png_rgb_unfilter_to_rgb555 NOT OK");
        $finish;
    end

    // result side: check each beat, stall at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                sb.check_result(m_pixel_word, m_screen_x, m_screen_y);
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    function automatic logic [7:0] rand_byte();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10) return 8'h00;
        if (pick < 20) return 8'hff;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_byte(input logic [7:0] b);
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(b);
        bytes_sent++;
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        send_byte(r);
        send_byte(g);
        send_byte(b);
        if (sb.alpha_r) send_byte(rand_byte());
    endtask

    task automatic send_line(input logic [7:0] filt, input int unsigned npix);
        send_byte(filt);
        repeat (npix) send_pixel(rand_byte(), rand_byte(), rand_byte());
    endtask

    // registers change only once the pipe has emptied
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input reg_sel_t r, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(r, v);
        @(posedge aclk);
    endtask

    task automatic set_config(input int unsigned w, input int unsigned alpha,
                              input int unsigned wide, input int unsigned ox,
                              input int unsigned oy, input int unsigned br);
        apb_write(REG_IMAGE_WIDTH, w);
        apb_write(REG_HAS_ALPHA, alpha);
        apb_write(REG_WIDE_SCREEN, wide);
        apb_write(REG_ORIGIN_X, ox);
        apb_write(REG_ORIGIN_Y, oy);
        apb_write(REG_BRIGHTNESS, br);
        settings++;
    endtask

    initial begin
        logic [7:0]  probe_filters [7];
        int unsigned mode_start;
        int unsigned w;
        int unsigned weff;
        int unsigned alpha;
        int unsigned wide;
        int unsigned size;
        int unsigned ox;
        int unsigned oy;
        int unsigned br;
        int unsigned nlines;
        int unsigned guard;

        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        s_valid     = 1'b0;
        s_data_byte = '0;
        aresetn     = 1'b0;
        send_idle   = 25;
        recv_idle   = 81;
        bytes_sent  = 0;
        settings    = 0;
        sb          = new();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // first row: widest line, saturating brightness, fills the first COVERED_COLS columns of the line store
        set_config(12'hfff, 0, 1, 0, 0, 127);
        send_byte(8'(FILT_PAETH));
        send_pixel(8'hff, 8'hff, 8'hff);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'h80, 8'h01, 8'hfe);
        repeat (COVERED_COLS - 4) send_pixel(rand_byte(), rand_byte(), rand_byte());
        // width drops below the column: the line closes after the next pixel
        wait_idle();
        apb_write(REG_IMAGE_WIDTH, 0);
        send_pixel(8'hff, 8'h00, 8'hff);

        // one pixel per line, every filter plus unknown codes
        probe_filters = '{8'(FILT_SUB), 8'(FILT_UP), 8'(FILT_AVG), 8'(FILT_PAETH),
                          8'(FILT_NONE), 8'd7, 8'hff};
        foreach (probe_filters[i]) send_line(probe_filters[i], 1);

        // alpha switched off and on part way through a pixel
        wait_idle();
        apb_write(REG_BRIGHTNESS, 0);
        apb_write(REG_HAS_ALPHA, 1);
        apb_write(REG_IMAGE_WIDTH, 2);
        send_line(8'(FILT_AVG), 1);
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h33);
        wait_idle();
        apb_write(REG_HAS_ALPHA, 0);
        send_byte(8'h44);
        send_byte(8'(FILT_SUB));
        send_byte(8'h55);
        wait_idle();
        apb_write(REG_HAS_ALPHA, 1);
        send_byte(8'h66);
        send_byte(8'h77);
        send_byte(8'h88);
        send_pixel(8'h01, 8'h80, 8'hff);

        // horizontal crop at the far screen edge
        wait_idle();
        set_config(3, 0, 1, 1023, 0, 1);
        send_line(8'(FILT_UP), 3);
        wait_idle();
        apb_write(REG_WIDE_SCREEN, 0);
        send_line(8'(FILT_PAETH), 3);

        // vertical crop: last visible row, then everything dropped
        wait_idle();
        apb_write(REG_ORIGIN_X, 0);
        apb_write(REG_ORIGIN_Y, SCREEN_NARROW - 1 - sb.row);
        send_line(8'(FILT_SUB), 3);
        send_line(8'(FILT_AVG), 3);
        wait_idle();
        apb_write(REG_ORIGIN_Y, 1023);
        send_line(8'(FILT_NONE), 3);

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_idle = 25;
                    recv_idle = 81;
                end
                1: begin
                    send_idle = 81;
                    recv_idle = 25;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            mode_start = bytes_sent;
            while (bytes_sent - mode_start < MODE_BYTES) begin
                wait_idle();
                case ($urandom_range(9))
                    0: w = 0;
                    1: w = COVERED_COLS;
                    2: w = $urandom_range(COVERED_COLS - 1, 9);
                    default: w = $urandom_range(8, 1);
                endcase
                weff  = (w == 0) ? 1 : w;
                alpha = $urandom_range(1);
                wide  = (sb.row >= 400) ? 1 : $urandom_range(1);
                size  = wide ? SCREEN_WIDE : SCREEN_NARROW;
                case ($urandom_range(3))
                    0: ox = 0;
                    1: ox = size - $urandom_range(weff, 1);
                    2: ox = $urandom_range(1023);
                    default: ox = $urandom_range(size - 1);
                endcase
                if ($urandom_range(5) == 0) oy = size - 1 - sb.row;
                else oy = $urandom_range(size - 1 - sb.row);
                case ($urandom_range(4))
                    0: br = 0;
                    1: br = 1;
                    2: br = BRIGHT_FULL;
                    3: br = 127;
                    default: br = $urandom_range(99, 2);
                endcase
                set_config(w, alpha, wide, ox, oy, br);

                // close any line left open under the new width
                while (!sb.await_filter && sb.live()) send_byte(rand_byte());
                nlines = (weff > 8) ? 1 : $urandom_range(6, 2);
                repeat (nlines) begin
                    if ($urandom_range(99) < 85) send_line(8'($urandom_range(4)), weff);
                    else send_line(8'($urandom_range(255, 5)), weff);
                end
                // leave a ragged tail now and then
                if ($urandom_range(99) < 30)
                    repeat ($urandom_range(7, 1)) send_byte(rand_byte());
            end
        end

        s_valid <= 1'b0;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.pending.size() != 0) begin
            $display("%0d pixel beats never arrived", sb.pending.size());
            sb.errors += sb.pending.size();
        end

        $display("stream bytes sent %0d, decoded %0d; pixel beats checked %0d; failures %0d",
                 bytes_sent, sb.decoded, sb.checked, sb.errors);
        $display("register settings %0d, all five filters, crops, alpha switching, stalls both ways",
                 settings);
        if (sb.errors == 0) begin
            $display("tb_png_rgb_unfilter_to_rgb555 OK");
        end else begin
            $display("tb_png_rgb_unfilter_to_rgb555 NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/pngu_pkg.sv
hw/rtl/pngu_front.sv
hw/rtl/pngu_queue.sv
hw/rtl/pngu_back.sv
hw/rtl/png_rgb_unfilter_to_rgb555.sv
bench/tb_png_rgb_unfilter_to_rgb555.sv
